/* rtl/keypad_debounce_single_key_core_assert.svh */
// assertion macros for the keypad debouncer core
`ifndef KEYPAD_DEBOUNCE_SINGLE_KEY_CORE_ASSERT_SVH
`define KEYPAD_DEBOUNCE_SINGLE_KEY_CORE_ASSERT_SVH

`ifndef SYNTH
`define KDSK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define KDSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KDSK_ASSERT_IMPL(lbl, ante, cons, msg)
`define KDSK_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/kdsk_pkg.sv */
// types, constants and microcode table of the keypad debouncer core
package kdsk_pkg;

  localparam int unsigned DEF_NUM_KEYS   = 8;
  localparam int unsigned STATUS_W       = 8;
  localparam int unsigned LIMIT_W        = 8;
  localparam int unsigned KEY_W          = 3;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 8;
  localparam int unsigned OUT_DATA_W     = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd20;
  localparam logic [KEY_W-1:0]   START_RST = 3'd0;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_KEY_INDEX = 1'd1;

  localparam int unsigned UPC_W = 3;

  // microcode addresses
  localparam logic [UPC_W-1:0] UA_WAIT  = 3'd0;
  localparam logic [UPC_W-1:0] UA_START = 3'd1;
  localparam logic [UPC_W-1:0] UA_KEY   = 3'd2;
  localparam logic [UPC_W-1:0] UA_EMIT  = 3'd3;
  localparam logic [UPC_W-1:0] UA_INIT  = 3'd4;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_START,
    UOP_KEY,
    UOP_EMIT,
    UOP_INIT
  } uop_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_ACC,
    COND_IS_INIT,
    COND_LAST_KEY,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    uop_e             op;
    cond_e            cond;
    logic [UPC_W-1:0] t_addr;
    logic [UPC_W-1:0] f_addr;
  } ucode_t;

  // result word, press_valid in bit 0
  typedef struct packed {
    logic [3:0]       pad;
    logic [KEY_W-1:0] active_key;
    logic             active_valid;
    logic [KEY_W-1:0] release_key;
    logic             release_valid;
    logic [KEY_W-1:0] press_key;
    logic             press_valid;
  } out_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    case (addr)
      UA_WAIT:  w = '{op: UOP_WAIT,  cond: COND_IN_ACC,   t_addr: UA_START, f_addr: UA_WAIT};
      UA_START: w = '{op: UOP_START, cond: COND_IS_INIT,  t_addr: UA_INIT,  f_addr: UA_KEY};
      UA_KEY:   w = '{op: UOP_KEY,   cond: COND_LAST_KEY, t_addr: UA_EMIT,  f_addr: UA_KEY};
      UA_EMIT:  w = '{op: UOP_EMIT,  cond: COND_OUT_FREE, t_addr: UA_WAIT,  f_addr: UA_EMIT};
      UA_INIT:  w = '{op: UOP_INIT,  cond: COND_ALWAYS,   t_addr: UA_EMIT,  f_addr: UA_EMIT};
      default:  w = '{op: UOP_WAIT,  cond: COND_ALWAYS,   t_addr: UA_WAIT,  f_addr: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* rtl/keypad_debounce_single_key_core.sv */
// keypad debouncer core: microcoded per-key scan with a single active key
// Each request is an init (tuser 0) or a scan tick (tuser 1) with the raw key levels in tdata,
// and gives exactly one result word. After acceptance, a tick runs the start, scan and emit steps
// before the next request can be taken, as the scan step visits one key per cycle through a
// shared counter-and-compare datapath; an init runs the start, init and emit steps instead.
// The result sits in an output register, so a stalled result does not hold off the next request,
// only the next result. Config writes take effect at once and are meant for idle periods.
`include "keypad_debounce_single_key_core_assert.svh"

module keypad_debounce_single_key_core import kdsk_pkg::*; #(
  parameter int unsigned NUM_KEYS = DEF_NUM_KEYS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [STATUS_W-1:0]   s_axis_tdata,   // key_status[7:0]
  input  logic                  s_axis_tuser,   // command
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // press_valid, press_key[2:0], release_valid,
                                                // release_key[2:0], active_valid,
                                                // active_key[2:0], zero pad
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [LIMIT_W-1:0]  limit_q;
  logic [KEY_W-1:0]    start_key_q;

  logic [UPC_W-1:0]    upc_q, upc_d;
  logic                cmd_q, cmd_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [KW-1:0]       idx_q, idx_d;
  logic [NUM_KEYS-1:0] level_q, level_d;
  logic [LIMIT_W-1:0]  count_q [NUM_KEYS];
  logic [LIMIT_W-1:0]  count_d [NUM_KEYS];
  logic                holder_v_q, holder_v_d;
  logic [KEY_W-1:0]    holder_key_q, holder_key_d;
  logic                flag_q, flag_d;
  logic                pv_q, pv_d, rv_q, rv_d;
  logic [KEY_W-1:0]    pk_q, pk_d, rk_q, rk_d;
  logic                m_tvalid_q, m_tvalid_d;
  out_t                out_q, out_d;

  ucode_t              uw;
  logic                in_acc, out_free, cond_ok, last_key;
  logic                raw, lvl, is_start, holder_match;
  logic [LIMIT_W-1:0]  cnt_inc;
  logic [KEY_W-1:0]    key3;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RST;
      start_key_q <= START_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE_LIMIT:  limit_q     <= cfg_data_i[LIMIT_W-1:0];
        CFG_START_KEY_INDEX: start_key_q <= cfg_data_i[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    uw            = ucode_rom(upc_q);
    s_axis_tready = (uw.op == UOP_WAIT);
    in_acc        = s_axis_tvalid && s_axis_tready;
    out_free      = !m_tvalid_q || m_axis_tready;
    last_key      = (int'(idx_q) == int'(NUM_KEYS) - 1);

    case (uw.cond)
      COND_ALWAYS:   cond_ok = 1'b1;
      COND_IN_ACC:   cond_ok = in_acc;
      COND_IS_INIT:  cond_ok = !cmd_q;
      COND_LAST_KEY: cond_ok = last_key;
      COND_OUT_FREE: cond_ok = out_free;
      default:       cond_ok = 1'b0;
    endcase
    upc_d = cond_ok ? uw.t_addr : uw.f_addr;

    // key under scan; keys past the status width read as released
    key3         = KEY_W'(32'(idx_q));
    raw          = (int'(idx_q) < int'(STATUS_W)) ? status_q[key3] : 1'b0;
    lvl          = level_q[idx_q];
    cnt_inc      = count_q[idx_q] + 8'd1;
    is_start     = (int'(idx_q) == int'(start_key_q));
    holder_match = holder_v_q && (int'(holder_key_q) == int'(idx_q));

    cmd_d        = cmd_q;
    status_d     = status_q;
    idx_d        = idx_q;
    level_d      = level_q;
    count_d      = count_q;
    holder_v_d   = holder_v_q;
    holder_key_d = holder_key_q;
    flag_d       = flag_q;
    pv_d         = pv_q;
    pk_d         = pk_q;
    rv_d         = rv_q;
    rk_d         = rk_q;
    m_tvalid_d   = m_tvalid_q && !m_axis_tready;
    out_d        = out_q;

    case (uw.op)
      UOP_WAIT: begin
        if (in_acc) begin
          cmd_d    = s_axis_tuser;
          status_d = s_axis_tdata;
        end
      end
      UOP_START: begin
        idx_d = '0;
        pv_d  = 1'b0;
        pk_d  = '0;
        rv_d  = 1'b0;
        rk_d  = '0;
      end
      UOP_KEY: begin
        idx_d = last_key ? '0 : KW'(idx_q + 1'b1);
        if (raw == lvl) begin
          count_d[idx_q] = '0;
        end else if (cnt_inc <= limit_q) begin
          count_d[idx_q] = cnt_inc;
        end else begin
          count_d[idx_q] = '0;
          level_d[idx_q] = raw;
          if (raw) begin
            if (!holder_v_q) begin
              holder_v_d   = 1'b1;
              holder_key_d = key3;
              if (!(flag_q && is_start)) begin
                pv_d = 1'b1;
                pk_d = key3;
              end
            end
          end else if (holder_match) begin
            holder_v_d   = 1'b0;
            holder_key_d = '0;
            if (flag_q && is_start) begin
              flag_d = 1'b0;
            end else begin
              rv_d = 1'b1;
              rk_d = key3;
            end
          end
        end
      end
      UOP_INIT: begin
        flag_d       = status_q[start_key_q];
        level_d      = '0;
        count_d      = '{default: '0};
        holder_v_d   = 1'b0;
        holder_key_d = '0;
      end
      UOP_EMIT: begin
        if (out_free) begin
          m_tvalid_d          = 1'b1;
          out_d.pad           = '0;
          out_d.press_valid   = pv_q;
          out_d.press_key     = pk_q;
          out_d.release_valid = rv_q;
          out_d.release_key   = rk_q;
          out_d.active_valid  = holder_v_q;
          out_d.active_key    = holder_key_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q        <= UA_WAIT;
      idx_q        <= '0;
      level_q      <= '0;
      count_q      <= '{default: '0};
      holder_v_q   <= 1'b0;
      holder_key_q <= '0;
      flag_q       <= 1'b0;
      pv_q         <= 1'b0;
      pk_q         <= '0;
      rv_q         <= 1'b0;
      rk_q         <= '0;
      m_tvalid_q   <= 1'b0;
    end else begin
      upc_q        <= upc_d;
      idx_q        <= idx_d;
      level_q      <= level_d;
      count_q      <= count_d;
      holder_v_q   <= holder_v_d;
      holder_key_q <= holder_key_d;
      flag_q       <= flag_d;
      pv_q         <= pv_d;
      pk_q         <= pk_d;
      rv_q         <= rv_d;
      rk_q         <= rk_d;
      m_tvalid_q   <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = out_q;

  `KDSK_ASSERT_NEXT(a_accept_starts_item, in_acc, upc_q == UA_START, "request not dispatched")
  `KDSK_ASSERT_IMPL(a_idx_in_range, 1'b1, int'(idx_q) < int'(NUM_KEYS), "scan index past last key")
  `KDSK_ASSERT_IMPL(a_holder_key_clear, !holder_v_q, holder_key_q == '0, "stale holder key")
  `KDSK_ASSERT_IMPL(a_release_before_press,
                    m_tvalid_q && out_q.press_valid && out_q.release_valid,
                    out_q.press_key > out_q.release_key, "press not after release in scan order")

endmodule
